FILE: hw/rtl/mcfe_pkg.sv
package mcfe_pkg;

    localparam int CMD_BITS   = 32;
    localparam int LIMIT_BITS = 31;
    localparam int NODE_BITS  = 8;
    localparam int CODE_BITS  = 16;
    localparam int IDENT_BITS = 29;
    localparam int FRAME_BITS = 64;

    localparam logic [4:0] MIT_COMM_TYPE = 5'd1;

    // clamp, scale by 65535, then one quotient bit per stage
    localparam int DIV_STEPS  = CODE_BITS;
    localparam int STG_CLAMP  = 0;
    localparam int STG_SCALE  = 1;
    localparam int STG_DIV0   = 2;
    localparam int NUM_STAGES = STG_DIV0 + DIV_STEPS;

    typedef enum logic [2:0] {
        REG_POSITION_LIMIT  = 3'd0,
        REG_VELOCITY_LIMIT  = 3'd1,
        REG_TORQUE_LIMIT    = 3'd2,
        REG_STIFFNESS_LIMIT = 3'd3,
        REG_DAMPING_LIMIT   = 3'd4,
        REG_NODE_ID         = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] position_limit;
        logic [LIMIT_BITS-1:0] velocity_limit;
        logic [LIMIT_BITS-1:0] torque_limit;
        logic [LIMIT_BITS-1:0] stiffness_limit;
        logic [LIMIT_BITS-1:0] damping_limit;
        logic [NODE_BITS-1:0]  node_id;
    } cfg_t;

endpackage

FILE: hw/rtl/mcfe_config.sv
module mcfe_config
    import mcfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_en,
    input  logic [2:0]            index,
    input  logic [LIMIT_BITS-1:0] wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                REG_POSITION_LIMIT:  cfg_next.position_limit  = wdata;
                REG_VELOCITY_LIMIT:  cfg_next.velocity_limit  = wdata;
                REG_TORQUE_LIMIT:    cfg_next.torque_limit    = wdata;
                REG_STIFFNESS_LIMIT: cfg_next.stiffness_limit = wdata;
                REG_DAMPING_LIMIT:   cfg_next.damping_limit   = wdata;
                REG_NODE_ID:         cfg_next.node_id         = wdata[NODE_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_limit  <= 31'd823550;
            cfg_reg.velocity_limit  <= 31'd2162688;
            cfg_reg.torque_limit    <= 31'd917504;
            cfg_reg.stiffness_limit <= 31'd32768000;
            cfg_reg.damping_limit   <= 31'd327680;
            cfg_reg.node_id         <= 8'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/mcfe_lane.sv
module mcfe_lane
    import mcfe_pkg::*;
(
    input  logic                  clk,
    input  logic [NUM_STAGES-1:0] en,
    input  logic [CMD_BITS-1:0]   cmd,
    input  logic [LIMIT_BITS-1:0] limit,
    input  logic                  symmetric,
    output logic [CODE_BITS-1:0]  code
);

    localparam int SPAN_BITS = LIMIT_BITS + 1;
    localparam int SUM_BITS  = CMD_BITS + 2;
    localparam int N_BITS    = SPAN_BITS + CODE_BITS;

    logic [LIMIT_BITS-1:0] lim_eff;
    logic [SPAN_BITS-1:0]  span;
    logic [SUM_BITS-1:0]   sum;
    logic [SPAN_BITS-1:0]  off_next;
    logic [SPAN_BITS-1:0]  off_reg;
    logic [N_BITS-1:0]     n_next;
    logic [N_BITS-1:0]     n_reg;

    // a zero limit acts as the smallest span
    assign lim_eff = (limit == '0) ? LIMIT_BITS'(1) : limit;
    assign span    = symmetric ? {lim_eff, 1'b0} : {1'b0, lim_eff};

    // shift the span floor to zero, then saturate against the span
    assign sum = {{2{cmd[CMD_BITS-1]}}, cmd}
               + (symmetric ? {3'b000, lim_eff} : SUM_BITS'(0));

    always_comb
    begin
        if (sum[SUM_BITS-1])
            off_next = '0;
        else if (sum > {2'b00, span})
            off_next = span;
        else
            off_next = sum[SPAN_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_CLAMP])
            off_reg <= off_next;
    end

    // off * 65535 as a shift and subtract
    assign n_next = {off_reg, {CODE_BITS{1'b0}}} - {{CODE_BITS{1'b0}}, off_reg};

    always_ff @(posedge clk)
    begin
        if (en[STG_SCALE])
            n_reg <= n_next;
    end

    // restoring division: low dividend bits shift out at the top of lq,
    // quotient bits shift in at the bottom
    logic [SPAN_BITS-1:0] rem_reg [DIV_STEPS-1];
    logic [CODE_BITS-1:0] lq_reg  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [SPAN_BITS-1:0] rem_in;
        logic [CODE_BITS-1:0] lq_in;
        logic [SPAN_BITS:0]   trial;
        logic [SPAN_BITS+1:0] diff;
        logic                 ge;
        logic [CODE_BITS-1:0] lq_next;

        if (k == 0)
        begin : g_first
            assign rem_in = n_reg[N_BITS-1:CODE_BITS];
            assign lq_in  = n_reg[CODE_BITS-1:0];
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign lq_in  = lq_reg[k-1];
        end

        assign trial   = {rem_in, lq_in[CODE_BITS-1]};
        assign diff    = {1'b0, trial} - {2'b00, span};
        assign ge      = ~diff[SPAN_BITS+1];
        assign lq_next = {lq_in[CODE_BITS-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en[STG_DIV0 + k])
                lq_reg[k] <= lq_next;
        end

        if (k < DIV_STEPS - 1)
        begin : g_rem
            logic [SPAN_BITS-1:0] rem_next;

            assign rem_next = ge ? diff[SPAN_BITS-1:0] : trial[SPAN_BITS-1:0];

            always_ff @(posedge clk)
            begin
                if (en[STG_DIV0 + k])
                    rem_reg[k] <= rem_next;
            end
        end
    end

    assign code = lq_reg[DIV_STEPS-1];

endmodule

FILE: hw/rtl/mit_command_frame_encoder.sv
// The result sits in the last of 18 register stages (clamp, scale, then 16
// divider stages, one quotient bit each).
// Throughput: one command per cycle; each stage holds under back-pressure
// while empty stages ahead of a stall still fill.
// Reset: rst_n clears all stage valid bits and loads the default limits
// and node 1; datapath registers are not reset.
module mit_command_frame_encoder
    import mcfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [2:0]            cfg_index,
    input  logic [LIMIT_BITS-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_BITS-1:0]   position_cmd,
    input  logic [CMD_BITS-1:0]   velocity_cmd,
    input  logic [CMD_BITS-1:0]   torque_cmd,
    input  logic [CMD_BITS-1:0]   stiffness_cmd,
    input  logic [CMD_BITS-1:0]   damping_cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IDENT_BITS-1:0] frame_ident,
    output logic [FRAME_BITS-1:0] frame_payload
);

    cfg_t cfg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    logic [CODE_BITS-1:0] pos_code;
    logic [CODE_BITS-1:0] vel_code;
    logic [CODE_BITS-1:0] trq_code;
    logic [CODE_BITS-1:0] kp_code;
    logic [CODE_BITS-1:0] kd_code;

    mcfe_config u_config (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .wdata    (cfg_wdata),
        .cfg      (cfg)
    );

    // a stage loads when it is empty or its contents move on
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_ready
        if (i == NUM_STAGES - 1)
        begin : g_last
            assign stage_en[i] = ~valid_reg[i] | out_ready;
        end
        else
        begin : g_mid
            assign stage_en[i] = ~valid_reg[i] | stage_en[i+1];
        end
    end

    assign valid_next = (stage_en & {valid_reg[NUM_STAGES-2:0], in_valid})
                      | (~stage_en & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    mcfe_lane u_pos (
        .clk       (clk),
        .en        (stage_en),
        .cmd       (position_cmd),
        .limit     (cfg.position_limit),
        .symmetric (1'b1),
        .code      (pos_code)
    );

    mcfe_lane u_vel (
        .clk       (clk),
        .en        (stage_en),
        .cmd       (velocity_cmd),
        .limit     (cfg.velocity_limit),
        .symmetric (1'b1),
        .code      (vel_code)
    );

    mcfe_lane u_trq (
        .clk       (clk),
        .en        (stage_en),
        .cmd       (torque_cmd),
        .limit     (cfg.torque_limit),
        .symmetric (1'b1),
        .code      (trq_code)
    );

    mcfe_lane u_kp (
        .clk       (clk),
        .en        (stage_en),
        .cmd       (stiffness_cmd),
        .limit     (cfg.stiffness_limit),
        .symmetric (1'b0),
        .code      (kp_code)
    );

    mcfe_lane u_kd (
        .clk       (clk),
        .en        (stage_en),
        .cmd       (damping_cmd),
        .limit     (cfg.damping_limit),
        .symmetric (1'b0),
        .code      (kd_code)
    );

    assign frame_ident   = {MIT_COMM_TYPE, trq_code, cfg.node_id};
    assign frame_payload = {pos_code, vel_code, kp_code, kd_code};

endmodule
